@@ hdl/tssca_pkg.sv @@
// Package with shared types, constants and codes for the sample cache allocator.
package tssca_pkg;

  localparam int MaxEntries = 32;
  localparam int AddrBits = 20;
  localparam int EntryIdxBits = $clog2(MaxEntries);
  localparam int CountBits = $clog2(MaxEntries + 1);
  localparam int SizeBits = 21;
  localparam logic [SizeBits-1:0] PoolLimit = 21'd1048576;
  localparam int QueueDepth = 2;

  typedef enum logic [2:0] {
    CMD_CLEAR = 3'd0,
    CMD_ALLOC_TEMP = 3'd1,
    CMD_ALLOC_PERSIST = 3'd2,
    CMD_ALLOC_PERSIST_ELSE_TEMP = 3'd3,
    CMD_GET_TEMP = 3'd4,
    CMD_GET_PERSIST = 3'd5,
    CMD_GET_PERSIST_ELSE_TEMP = 3'd6,
    CMD_UNUSED = 3'd7
  } command_t;

  typedef enum logic [2:0] {
    OC_OK = 3'd0,
    OC_NOT_FOUND = 3'd1,
    OC_NO_SPACE = 3'd2,
    OC_BOTH_LOADING = 3'd3,
    OC_TABLE_FULL = 3'd4
  } outcome_t;

  localparam logic [1:0] ST_NOT_LOADED = 2'd0;
  localparam logic [1:0] ST_LOADING = 2'd1;
  localparam logic [1:0] ST_DISCARDABLE = 2'd3;

  localparam logic [1:0] REG_TEMP_POOL = 2'd0;
  localparam logic [1:0] REG_PERSIST_POOL = 2'd1;
  localparam logic [1:0] REG_KIND_IS_BANK = 2'd2;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] asset_id;
    logic [20:0] size_bytes;
    logic [7:0] unit_count;
    logic [1:0] low_side_status;
    logic [1:0] high_side_status;
  } in_item_t;

  typedef struct packed {
    logic [2:0] outcome;
    logic [19:0] offset;
    logic from_persistent;
    logic victim_valid;
    logic [7:0] victim_id;
    logic victim_discard;
    logic overlap_valid;
    logic [7:0] overlap_id;
  } out_item_t;

  // Classified request handed from the front part to the back part.
  typedef struct packed {
    in_item_t item;
    logic [29:0] need;
  } work_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DECIDE,
    S_SCAN,
    S_TEMP,
    S_DONE
  } back_state_t;

endpackage

@@ hdl/tssca_front.sv @@
// Front part: accepts request beats, computes the aligned persistent size and queues them.
module tssca_front (
  input  logic clk,
  input  logic rst,
  input  logic valid,
  output logic ready,
  input  tssca_pkg::in_item_t in_item,
  output logic work_valid,
  input  logic work_ready,
  output tssca_pkg::work_t work
);
  import tssca_pkg::*;

  localparam int PtrBits = $clog2(QueueDepth);

  work_t queue [QueueDepth];
  logic [PtrBits-1:0] wr_ptr;
  logic [PtrBits-1:0] rd_ptr;
  logic [PtrBits:0] fill;
  in_item_t staged;
  logic staged_valid;
  logic [28:0] product;
  work_t entry;
  logic push;
  logic pop;
  logic take;

  assign ready = !staged_valid;
  assign take = valid && ready;
  assign push = staged_valid && (fill != (PtrBits + 1)'(QueueDepth));
  assign pop = work_valid && work_ready;
  assign work_valid = fill != '0;
  assign work = queue[rd_ptr];

  always_comb begin
    product = 29'(staged.size_bytes) * 29'(staged.unit_count);
    entry.item = staged;
    entry.need = (30'(product) + 30'hF) & ~30'hF;
  end

  always_ff @(posedge clk) begin
    if (take) begin
      staged <= in_item;
    end
    if (push) begin
      queue[wr_ptr] <= entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      staged_valid <= 1'b0;
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (take) begin
        staged_valid <= 1'b1;
      end else if (push) begin
        staged_valid <= 1'b0;
      end
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      fill <= fill + (PtrBits + 1)'(push) - (PtrBits + 1)'(pop);
    end
  end

endmodule

@@ hdl/tssca_back.sv @@
// Back part: carries out clears, allocations and lookups against the pool state.
module tssca_back (
  input  logic clk,
  input  logic rst,
  input  logic work_valid,
  output logic work_ready,
  input  tssca_pkg::work_t work,
  input  logic [20:0] temp_pool_bytes,
  input  logic [20:0] persist_pool_bytes,
  input  logic kind_is_bank,
  output logic result_valid,
  input  logic result_ready,
  output tssca_pkg::out_item_t result
);
  import tssca_pkg::*;

  back_state_t state;
  back_state_t state_next;
  work_t cur;
  logic [EntryIdxBits-1:0] scan_idx;
  logic [EntryIdxBits-1:0] rd_addr;

  logic side_valid [2];
  logic [7:0] side_id [2];
  logic [20:0] side_offset [2];
  logic [20:0] temp_cursor;
  logic next_side;
  logic [7:0] persist_id [MaxEntries];
  logic [20:0] persist_offset [MaxEntries];
  logic [20:0] persist_cursor;
  logic [CountBits-1:0] persist_count;
  logic [7:0] rd_id;
  logic [20:0] rd_offset;
  logic persist_we;

  logic [1:0] s0;
  logic [1:0] s1;
  logic side;
  logic other;
  logic both_loading;
  logic oversize;
  logic [20:0] new_high;
  logic [20:0] new_cursor;
  logic overlap;
  logic full;
  logic fits;
  logic [30:0] persist_end;
  logic hit0;
  logic hit1;
  logic scan_live;
  logic persist_hit;
  command_t cmd;

  assign cmd = command_t'(cur.item.command);
  assign result_valid = state == S_DONE;
  assign work_ready = state == S_IDLE;
  assign rd_addr = (state == S_SCAN) ? scan_idx + 1'b1 : scan_idx;
  assign persist_we = !rst && state == S_DECIDE && !full && fits
                      && (cmd == CMD_ALLOC_PERSIST || cmd == CMD_ALLOC_PERSIST_ELSE_TEMP);

  always_comb begin
    s0 = side_valid[0] ? cur.item.low_side_status : ST_NOT_LOADED;
    s1 = side_valid[1] ? cur.item.high_side_status : ST_NOT_LOADED;
    both_loading = 1'b0;
    if (s0 == ST_NOT_LOADED) begin
      side = 1'b0;
    end else if (s1 == ST_NOT_LOADED) begin
      side = 1'b1;
    end else if (s0 == ST_DISCARDABLE && s1 == ST_DISCARDABLE) begin
      side = next_side;
    end else if (s0 == ST_DISCARDABLE) begin
      side = 1'b0;
    end else if (s1 == ST_DISCARDABLE) begin
      side = 1'b1;
    end else if (s0 != ST_LOADING) begin
      side = 1'b0;
    end else if (s1 != ST_LOADING) begin
      side = 1'b1;
    end else begin
      side = 1'b0;
      both_loading = 1'b1;
    end
    other = !side;
    if (!side) begin
      oversize = cur.item.size_bytes > temp_pool_bytes;
    end else begin
      oversize = (22'(cur.item.size_bytes) + 22'd16) > 22'(temp_pool_bytes);
    end
    new_high = temp_pool_bytes - cur.item.size_bytes - 21'd16;
    new_cursor = side ? temp_cursor : cur.item.size_bytes;
    overlap = (side ? new_high : side_offset[1]) < new_cursor;
    full = persist_count >= CountBits'(MaxEntries);
    persist_end = 31'(persist_cursor) + 31'(cur.need);
    fits = persist_end <= 31'(persist_pool_bytes);
    hit0 = side_valid[0] && side_id[0] == cur.item.asset_id;
    hit1 = side_valid[1] && side_id[1] == cur.item.asset_id;
    scan_live = CountBits'(scan_idx) < persist_count;
    persist_hit = scan_live && rd_id == cur.item.asset_id;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (work_valid) state_next = S_MUL;
      S_MUL: state_next = S_DECIDE;
      S_DECIDE: begin
        case (cmd)
          CMD_ALLOC_PERSIST_ELSE_TEMP:
            state_next = (!full && fits) ? S_DONE : S_TEMP;
          CMD_ALLOC_TEMP, CMD_GET_TEMP: state_next = S_TEMP;
          CMD_GET_PERSIST, CMD_GET_PERSIST_ELSE_TEMP: state_next = S_SCAN;
          default: state_next = S_DONE;
        endcase
      end
      S_SCAN: begin
        if (persist_hit) begin
          state_next = S_DONE;
        end else if (!scan_live || scan_idx == EntryIdxBits'(MaxEntries - 1)) begin
          state_next = (cmd == CMD_GET_PERSIST_ELSE_TEMP) ? S_TEMP : S_DONE;
        end
      end
      S_TEMP: state_next = S_DONE;
      S_DONE: if (result_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (persist_we) begin
      persist_id[persist_count[EntryIdxBits-1:0]] <= cur.item.asset_id;
      persist_offset[persist_count[EntryIdxBits-1:0]] <= persist_cursor;
    end
    rd_id <= persist_id[rd_addr];
    rd_offset <= persist_offset[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side_valid[0] <= 1'b0;
      side_valid[1] <= 1'b0;
      side_id[0] <= '0;
      side_id[1] <= '0;
      side_offset[0] <= '0;
      side_offset[1] <= '0;
      temp_cursor <= '0;
      next_side <= 1'b0;
      persist_cursor <= '0;
      persist_count <= '0;
      scan_idx <= '0;
    end else begin
      if (state == S_IDLE && work_valid) begin
        cur <= work;
        result <= '0;
        scan_idx <= '0;
      end
      if (state == S_DECIDE) begin
        case (cmd)
          CMD_CLEAR: begin
            temp_cursor <= '0;
            next_side <= 1'b0;
            side_valid[0] <= 1'b0;
            side_valid[1] <= 1'b0;
            side_id[0] <= '0;
            side_id[1] <= '0;
            side_offset[0] <= '0;
            side_offset[1] <= temp_pool_bytes;
            persist_cursor <= '0;
            persist_count <= '0;
          end
          CMD_ALLOC_PERSIST, CMD_ALLOC_PERSIST_ELSE_TEMP: begin
            if (!full && fits) begin
              persist_count <= persist_count + 1'b1;
              persist_cursor <= persist_end[20:0];
              result.offset <= persist_cursor[19:0];
              result.from_persistent <= 1'b1;
            end else if (cmd == CMD_ALLOC_PERSIST) begin
              result.outcome <= full ? OC_TABLE_FULL : OC_NO_SPACE;
            end
          end
          CMD_ALLOC_TEMP, CMD_GET_TEMP, CMD_GET_PERSIST, CMD_GET_PERSIST_ELSE_TEMP: ;
          default: result.outcome <= OC_NOT_FOUND;
        endcase
      end
      if (state == S_SCAN) begin
        if (persist_hit) begin
          result.offset <= rd_offset[19:0];
          result.from_persistent <= 1'b1;
        end else begin
          scan_idx <= scan_idx + 1'b1;
          if ((!scan_live || scan_idx == EntryIdxBits'(MaxEntries - 1))
              && cmd == CMD_GET_PERSIST) begin
            result.outcome <= OC_NOT_FOUND;
          end
        end
      end
      if (state == S_TEMP) begin
        if (cmd == CMD_GET_TEMP || cmd == CMD_GET_PERSIST_ELSE_TEMP) begin
          if (hit0) begin
            next_side <= 1'b1;
            result.offset <= side_offset[0][19:0];
          end else if (hit1) begin
            next_side <= 1'b0;
            result.offset <= side_offset[1][19:0];
          end else begin
            result.outcome <= OC_NOT_FOUND;
          end
        end else if (both_loading) begin
          result.outcome <= OC_BOTH_LOADING;
        end else if (oversize) begin
          result.outcome <= OC_NO_SPACE;
        end else begin
          result.victim_valid <= side_valid[side];
          result.victim_id <= side_valid[side] ? side_id[side] : 8'd0;
          result.victim_discard <= side_valid[side] & kind_is_bank;
          side_valid[side] <= 1'b1;
          side_id[side] <= cur.item.asset_id;
          next_side <= other;
          if (!side) begin
            side_offset[0] <= '0;
            result.offset <= '0;
          end
          if (overlap) begin
            result.overlap_valid <= side_valid[other];
            result.overlap_id <= side_valid[other] ? side_id[other] : 8'd0;
            side_valid[other] <= 1'b0;
            side_id[other] <= '0;
            if (!side) begin
              side_offset[1] <= temp_pool_bytes;
              temp_cursor <= cur.item.size_bytes;
            end else begin
              side_offset[1] <= new_high;
              temp_cursor <= '0;
              result.offset <= new_high[19:0];
            end
          end else begin
            if (!side) begin
              temp_cursor <= cur.item.size_bytes;
            end else begin
              side_offset[1] <= new_high;
              result.offset <= new_high[19:0];
            end
          end
        end
      end
    end
  end

endmodule

@@ hdl/two_sided_sample_cache_allocator.sv @@
// Top level of the two-sided sample cache allocator.
// Each request beat yields one result beat. A result is offered once its request has
// passed the multiply and decide steps, and the temporary pool step when it goes
// through that pool; a persistent lookup walks the entry table one entry per cycle
// through a registered memory read. The front part holds one staged beat and a
// two-entry queue, so requests are taken while the back part works.
module two_sided_sample_cache_allocator (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  tssca_pkg::in_item_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output tssca_pkg::out_item_t out_data,
  input  logic cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [20:0] cfg_data
);
  import tssca_pkg::*;

  logic [20:0] temp_pool_bytes;
  logic [20:0] persist_pool_bytes;
  logic kind_is_bank;
  logic [20:0] cfg_sat;
  logic work_valid;
  logic work_ready;
  work_t work;

  assign cfg_sat = (cfg_data > PoolLimit) ? PoolLimit : cfg_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_pool_bytes <= '0;
      persist_pool_bytes <= '0;
      kind_is_bank <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TEMP_POOL: temp_pool_bytes <= cfg_sat;
        REG_PERSIST_POOL: persist_pool_bytes <= cfg_sat;
        REG_KIND_IS_BANK: kind_is_bank <= cfg_data[0];
        default: ;
      endcase
    end
  end

  tssca_front u_front (
    .clk(clk),
    .rst(rst),
    .valid(in_valid),
    .ready(in_ready),
    .in_item(in_data),
    .work_valid(work_valid),
    .work_ready(work_ready),
    .work(work)
  );

  tssca_back u_back (
    .clk(clk),
    .rst(rst),
    .work_valid(work_valid),
    .work_ready(work_ready),
    .work(work),
    .temp_pool_bytes(temp_pool_bytes),
    .persist_pool_bytes(persist_pool_bytes),
    .kind_is_bank(kind_is_bank),
    .result_valid(out_valid),
    .result_ready(out_ready),
    .result(out_data)
  );

  a_cfg_limit: assert property (@(posedge clk) disable iff (rst)
    temp_pool_bytes <= PoolLimit && persist_pool_bytes <= PoolLimit)
    else $error("pool size above limit");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  a_ok_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.outcome != OC_OK |->
      out_data.offset == '0 && !out_data.victim_valid && !out_data.overlap_valid)
    else $error("failed result carries data");

endmodule

@@ tb/sv/tssca_checker.sv @@
`timescale 1ns / 1ps
// Checker that predicts allocator results from observed beats and compares them.
module tssca_checker (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic in_ready,
  input  tssca_pkg::in_item_t in_data,
  input  logic out_valid,
  input  logic out_ready,
  input  tssca_pkg::out_item_t out_data,
  input  logic cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [20:0] cfg_data,
  output int fail_count,
  output int pending,
  output int result_count
);
  import tssca_pkg::*;

  logic [20:0] temp_bytes, persist_bytes;
  logic bank_kind;
  logic slot_valid [2];
  logic [7:0] slot_id [2];
  logic [20:0] slot_ofs [2];
  logic [20:0] temp_top;
  logic turn;
  logic [7:0] tab_id [MaxEntries];
  logic [20:0] tab_ofs [MaxEntries];
  logic [20:0] bump;
  int tab_used;
  out_item_t expected_results [$];

  function automatic logic [20:0] sat_pool(input logic [20:0] v);
    return (v > PoolLimit) ? PoolLimit : v;
  endfunction

  task automatic reset_pools();
    temp_top = '0;
    turn = 1'b0;
    slot_valid[0] = 1'b0;
    slot_valid[1] = 1'b0;
    slot_id[0] = '0;
    slot_id[1] = '0;
    slot_ofs[0] = '0;
    slot_ofs[1] = temp_bytes;
    bump = '0;
    tab_used = 0;
  endtask

  task automatic place_temp(input in_item_t it, inout out_item_t r);
    logic [1:0] s0, s1;
    int side, other;
    logic [21:0] hi;
    s0 = slot_valid[0] ? it.low_side_status : ST_NOT_LOADED;
    s1 = slot_valid[1] ? it.high_side_status : ST_NOT_LOADED;
    if (s0 == ST_NOT_LOADED) side = 0;
    else if (s1 == ST_NOT_LOADED) side = 1;
    else if (s0 == ST_DISCARDABLE && s1 == ST_DISCARDABLE) side = turn;
    else if (s0 == ST_DISCARDABLE) side = 0;
    else if (s1 == ST_DISCARDABLE) side = 1;
    else if (s0 != ST_LOADING) side = 0;
    else if (s1 != ST_LOADING) side = 1;
    else begin
      r.outcome = OC_BOTH_LOADING;
      return;
    end
    if (side == 0 && it.size_bytes > temp_bytes ||
        side == 1 && {1'b0, it.size_bytes} + 22'd16 > {1'b0, temp_bytes}) begin
      r.outcome = OC_NO_SPACE;
      return;
    end
    other = 1 - side;
    if (slot_valid[side]) begin
      r.victim_valid = 1'b1;
      r.victim_id = slot_id[side];
      r.victim_discard = bank_kind;
    end
    slot_valid[side] = 1'b1;
    slot_id[side] = it.asset_id;
    if (side == 0) begin
      slot_ofs[0] = '0;
      temp_top = it.size_bytes;
    end else begin
      hi = {1'b0, temp_bytes} - {1'b0, it.size_bytes} - 22'd16;
      slot_ofs[1] = hi[20:0];
    end
    if (slot_ofs[1] < temp_top) begin
      if (slot_valid[other]) begin
        r.overlap_valid = 1'b1;
        r.overlap_id = slot_id[other];
      end
      slot_valid[other] = 1'b0;
      slot_id[other] = '0;
      if (side == 0) slot_ofs[1] = temp_bytes;
      else temp_top = '0;
    end
    r.offset = slot_ofs[side][19:0];
    turn = other[0];
  endtask

  function automatic logic find_temp(input logic [7:0] id, inout out_item_t r);
    for (int s = 0; s < 2; s++) begin
      if (slot_valid[s] && slot_id[s] == id) begin
        turn = (s == 0);
        r.offset = slot_ofs[s][19:0];
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  task automatic predict_request(input in_item_t it);
    out_item_t r;
    logic [29:0] need;
    logic hit;
    logic [2:0] oc;
    r = '0;
    r.outcome = OC_OK;
    case (command_t'(it.command))
      CMD_CLEAR: reset_pools();
      CMD_ALLOC_TEMP: place_temp(it, r);
      CMD_ALLOC_PERSIST, CMD_ALLOC_PERSIST_ELSE_TEMP: begin
        need = (30'(it.unit_count) * 30'(it.size_bytes) + 30'hF) & ~30'hF;
        if (tab_used < MaxEntries && 31'(bump) + 31'(need) <= 31'(persist_bytes)) begin
          tab_id[tab_used] = it.asset_id;
          tab_ofs[tab_used] = bump;
          tab_used++;
          r.offset = bump[19:0];
          r.from_persistent = 1'b1;
          bump = bump + need[20:0];
        end else if (it.command == CMD_ALLOC_PERSIST_ELSE_TEMP) begin
          place_temp(it, r);
        end else begin
          r.outcome = (tab_used >= MaxEntries) ? OC_TABLE_FULL : OC_NO_SPACE;
        end
      end
      CMD_GET_TEMP: if (!find_temp(it.asset_id, r)) r.outcome = OC_NOT_FOUND;
      CMD_GET_PERSIST, CMD_GET_PERSIST_ELSE_TEMP: begin
        hit = 1'b0;
        for (int i = 0; i < tab_used; i++) begin
          if (!hit && tab_id[i] == it.asset_id) begin
            r.offset = tab_ofs[i][19:0];
            r.from_persistent = 1'b1;
            hit = 1'b1;
          end
        end
        if (!hit && it.command == CMD_GET_PERSIST_ELSE_TEMP) hit = find_temp(it.asset_id, r);
        if (!hit) r.outcome = OC_NOT_FOUND;
      end
      default: r.outcome = OC_NOT_FOUND;
    endcase
    if (r.outcome != OC_OK) begin
      oc = r.outcome;
      r = '0;
      r.outcome = oc;
    end
    expected_results.push_back(r);
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      temp_bytes = '0;
      persist_bytes = '0;
      bank_kind = 1'b0;
      reset_pools();
      expected_results.delete();
      fail_count = 0;
      result_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        result_count++;
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("ERROR: unexpected result beat %p", out_data);
        end else begin
          want = expected_results.pop_front();
          if (out_data !== want) begin
            fail_count++;
            if (fail_count <= 10) $display("ERROR: result mismatch, expected %p, got %p",
                                           want, out_data);
          end
        end
      end
      if (in_valid && in_ready) predict_request(in_data);
      if (cfg_we) begin
        case (cfg_index)
          REG_TEMP_POOL: temp_bytes = sat_pool(cfg_data);
          REG_PERSIST_POOL: persist_bytes = sat_pool(cfg_data);
          REG_KIND_IS_BANK: bank_kind = cfg_data[0];
          default: ;
        endcase
      end
    end
    pending = expected_results.size();
  end
endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// Top of the allocator testbench: stimulus, configuration phases and verdict.
module tb_top;
  import tssca_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [20:0] cfg_data = '0;
  int fail_count, pending, result_count;
  int sent = 0;
  int idle_cycles = 0;
  int rx_wait = 0;
  logic hold_off = 1'b0;
  logic stim_done = 1'b0;

  always #6 clk = ~clk;

  two_sided_sample_cache_allocator i_dut (.*);

  tssca_checker i_checker (.*);

  task automatic write_reg(input logic [1:0] idx, input logic [20:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_request(input command_t c, input logic [7:0] id, input logic [20:0] sz,
                              input logic [7:0] cnt, input logic [1:0] lo,
                              input logic [1:0] hi);
    in_item_t it;
    int n;
    n = $urandom_range(0, 12);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    it.command = c;
    it.asset_id = id;
    it.size_bytes = sz;
    it.unit_count = cnt;
    it.low_side_status = lo;
    it.high_side_status = hi;
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic random_request(input logic [20:0] span);
    logic [20:0] sz;
    command_t c;
    logic [7:0] id;
    logic [7:0] cnt;
    case ($urandom_range(0, 9))
      0: sz = 21'($urandom_range(0, 21'h1FFFFF));
      1: sz = span;
      default: sz = 21'($urandom_range(0, span / 3 + 1));
    endcase
    if ($urandom_range(0, 40) == 0) c = CMD_CLEAR;
    else if ($urandom_range(0, 30) == 0) c = CMD_UNUSED;
    else c = command_t'(3'($urandom_range(1, 6)));
    id = 8'($urandom_range(0, 15)) | (($urandom_range(0, 7) == 0) ? 8'hF0 : 8'h00);
    cnt = ($urandom_range(0, 5) == 0) ? 8'($urandom_range(0, 255)) :
          8'($urandom_range(0, 4));
    send_request(c, id, sz, cnt, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
  endtask

  always @(posedge clk) begin
    int w;
    if (hold_off) begin
      out_ready <= 1'b0;
    end else if (out_valid && out_ready) begin
      w = $urandom_range(0, 12);
      rx_wait <= w;
      out_ready <= (w == 0);
    end else if (!out_ready) begin
      if (rx_wait <= 1) begin
        out_ready <= 1'b1;
        rx_wait <= 0;
      end else begin
        rx_wait <= rx_wait - 1;
      end
    end
  end

  initial begin
    repeat (20 * 12 + 400) @(posedge clk);
    hold_off <= 1'b1;
    repeat (300) @(posedge clk);
    hold_off <= 1'b0;
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    logic [20:0] span;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    write_reg(REG_TEMP_POOL, 21'd4096);
    write_reg(REG_PERSIST_POOL, 21'd2048);
    write_reg(REG_KIND_IS_BANK, 21'd1);
    send_request(CMD_ALLOC_TEMP, 8'd1, 21'd100, 8'd0, 2'd0, 2'd0);
    send_request(CMD_ALLOC_TEMP, 8'd2, 21'd200, 8'd0, 2'd2, 2'd0);
    send_request(CMD_ALLOC_TEMP, 8'd3, 21'd10, 8'd0, 2'd1, 2'd1);
    send_request(CMD_ALLOC_TEMP, 8'd4, 21'd50, 8'd0, 2'd3, 2'd3);
    send_request(CMD_ALLOC_TEMP, 8'd5, 21'd4000, 8'd0, 2'd2, 2'd3);
    send_request(CMD_ALLOC_TEMP, 8'd6, 21'd4090, 8'd0, 2'd3, 2'd1);
    send_request(CMD_ALLOC_TEMP, 8'd7, 21'h1FFFFF, 8'd0, 2'd0, 2'd0);
    send_request(CMD_GET_TEMP, 8'd5, 21'd0, 8'd0, 2'd0, 2'd0);
    send_request(CMD_GET_TEMP, 8'd99, 21'd0, 8'd0, 2'd0, 2'd0);
    send_request(CMD_ALLOC_PERSIST, 8'd255, 21'd3, 8'd255, 2'd0, 2'd0);
    send_request(CMD_ALLOC_PERSIST, 8'd0, 21'd1, 8'd1, 2'd0, 2'd0);
    send_request(CMD_ALLOC_PERSIST, 8'd9, 21'h1FFFFF, 8'd255, 2'd0, 2'd0);
    send_request(CMD_ALLOC_PERSIST_ELSE_TEMP, 8'd10, 21'd64, 8'd255, 2'd2, 2'd2);
    send_request(CMD_GET_PERSIST, 8'd0, 21'd0, 8'd0, 2'd0, 2'd0);
    send_request(CMD_GET_PERSIST, 8'd77, 21'd0, 8'd0, 2'd0, 2'd0);
    send_request(CMD_GET_PERSIST_ELSE_TEMP, 8'd10, 21'd0, 8'd0, 2'd0, 2'd0);
    send_request(CMD_UNUSED, 8'd1, 21'd0, 8'd0, 2'd0, 2'd0);
    send_request(CMD_CLEAR, 8'd0, 21'd0, 8'd0, 2'd0, 2'd0);
    drain();
    write_reg(REG_PERSIST_POOL, 21'd1048576);
    write_reg(REG_TEMP_POOL, 21'd1048576);
    for (int i = 0; i < 34; i++) send_request(CMD_ALLOC_PERSIST, 8'(i), 21'd0, 8'd0, 2'd0, 2'd0);
    send_request(CMD_GET_PERSIST, 8'd31, 21'd0, 8'd0, 2'd0, 2'd0);
    send_request(CMD_ALLOC_TEMP, 8'd1, 21'd1048576, 8'd0, 2'd0, 2'd0);
    send_request(CMD_ALLOC_TEMP, 8'd2, 21'd0, 8'd0, 2'd3, 2'd0);
    send_request(CMD_CLEAR, 8'd0, 21'd0, 8'd0, 2'd0, 2'd0);
    for (int phase = 0; phase < 6; phase++) begin
      drain();
      case (phase)
        0: span = 21'd0;
        1: span = 21'h1FFFFF;
        2: span = 21'd1048576;
        default: span = 21'($urandom_range(16, 8192));
      endcase
      write_reg(REG_TEMP_POOL, span);
      write_reg(REG_PERSIST_POOL, phase == 0 ? 21'd0 : 21'($urandom_range(0, 21'h1FFFFF)));
      write_reg(REG_KIND_IS_BANK, 21'(phase[0]));
      if (span > PoolLimit) span = PoolLimit;
      for (int k = 0; k < 230; k++) random_request(span);
    end
    drain();
    stim_done <= 1'b1;
  end

  initial begin
    wait (stim_done);
    @(posedge clk);
    $display("Sent %0d requests and checked %0d results over six pool settings,", sent,
             result_count);
    $display("including a long output stall and a full persistent entry table.");
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

@@ files.f @@
hdl/tssca_pkg.sv
hdl/tssca_front.sv
hdl/tssca_back.sv
hdl/two_sided_sample_cache_allocator.sv
tb/sv/tssca_checker.sv
tb/sv/tb_top.sv
